>>> hw/rtl/metasprite_oam_expander_assert.svh
// Assertion macros shared by the metasprite object attribute expander.
// Users must have clk and rst in scope; no other dependencies.
`ifndef METASPRITE_OAM_EXPANDER_ASSERT_SVH
`define METASPRITE_OAM_EXPANDER_ASSERT_SVH

// Clocked assertion with a synchronous reset that disables the check.
`define MSOE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MSOE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/msoe_pkg.sv
// Package for the metasprite object attribute expander: request and entry
// types, size tables and widths. No dependencies.
package msoe_pkg;

  localparam int OBJ_SLOTS_DEF = 128;
  localparam int SLOT_W        = 7;
  localparam int IN_DATA_W     = 120;
  localparam int OUT_DATA_W    = 56;
  localparam int SIZE_W        = 7;

  // Request fields, last field in the lowest bits.
  typedef struct packed {
    logic [15:0]       pivot;
    logic [9:0]        tile_offset;
    logic signed [7:0] part_dy;
    logic signed [8:0] part_dx;
    logic [15:0]       attr_two;
    logic [15:0]       attr_one;
    logic [15:0]       attr_zero;
    logic [9:0]        tile_base;
    logic [1:0]        flip;
    logic [7:0]        base_y;
    logic [8:0]        base_x;
  } part_t;

  typedef struct packed {
    logic [15:0]       out_attr_two;
    logic [15:0]       out_attr_one;
    logic [15:0]       out_attr_zero;
    logic [SLOT_W-1:0] slot_index;
  } entry_t;

  // Index is shape * 4 + size. Shape three reads as 8x8.
  function automatic logic [SIZE_W-1:0] size_width(input logic [3:0] idx);
    logic [SIZE_W-1:0] w;
    unique case (idx)
      4'd0:    w = 7'd8;
      4'd1:    w = 7'd16;
      4'd2:    w = 7'd32;
      4'd3:    w = 7'd64;
      4'd4:    w = 7'd16;
      4'd5:    w = 7'd32;
      4'd6:    w = 7'd32;
      4'd7:    w = 7'd64;
      4'd8:    w = 7'd8;
      4'd9:    w = 7'd8;
      4'd10:   w = 7'd16;
      4'd11:   w = 7'd32;
      default: w = 7'd8;
    endcase
    return w;
  endfunction

  function automatic logic [SIZE_W-1:0] size_height(input logic [3:0] idx);
    logic [SIZE_W-1:0] h;
    unique case (idx)
      4'd0:    h = 7'd8;
      4'd1:    h = 7'd16;
      4'd2:    h = 7'd32;
      4'd3:    h = 7'd64;
      4'd4:    h = 7'd8;
      4'd5:    h = 7'd8;
      4'd6:    h = 7'd16;
      4'd7:    h = 7'd32;
      4'd8:    h = 7'd16;
      4'd9:    h = 7'd32;
      4'd10:   h = 7'd32;
      4'd11:   h = 7'd64;
      default: h = 7'd8;
    endcase
    return h;
  endfunction

endpackage

>>> hw/rtl/msoe_part_calc.sv
// Combinational conversion of one registered metasprite part into an
// object attribute entry. Depends on msoe_pkg.
module msoe_part_calc (
  input  msoe_pkg::part_t                  part,
  input  logic [msoe_pkg::SLOT_W-1:0]      slot,
  output msoe_pkg::entry_t                 entry
);

  logic [15:0]               a1_flip;
  logic [15:0]               a2_tile;
  logic [9:0]                tile_sum;
  logic [3:0]                size_idx;
  logic [msoe_pkg::SIZE_W-1:0] w;
  logic [msoe_pkg::SIZE_W-1:0] h;
  logic [8:0]                cx;
  logic [7:0]                cy;
  logic [8:0]                dx;
  logic [7:0]                dy;
  logic [8:0]                px;
  logic [7:0]                py;

  always_comb begin
    a1_flip = part.attr_one;
    if (!part.attr_zero[8]) begin
      a1_flip[13:12] = part.attr_one[13:12] ^ part.flip;
    end

    tile_sum = part.tile_base + part.tile_offset;
    a2_tile  = part.attr_two;
    if (part.attr_two[9:0] == 10'd0) begin
      a2_tile[9:0] = tile_sum;
    end

    size_idx = {part.attr_zero[15:14], a1_flip[15:14]};
    w = msoe_pkg::size_width(size_idx);
    h = msoe_pkg::size_height(size_idx);

    cx = {part.pivot[15], part.pivot[15:8]};
    cy = part.pivot[7:0];

    dx = part.part_dx;
    if (part.flip[0]) begin
      dx = (cx << 1) - part.part_dx - {2'b00, w};
    end
    dy = part.part_dy;
    if (part.flip[1]) begin
      dy = (cy << 1) - part.part_dy - {1'b0, w[msoe_pkg::SIZE_W-1:0] & 7'd0} - {1'b0, h};
    end

    px = part.base_x + dx;
    py = part.base_y + dy;

    entry.slot_index    = slot;
    entry.out_attr_zero = {part.attr_zero[15:8], py};
    entry.out_attr_one  = {a1_flip[15:9], px};
    entry.out_attr_two  = a2_tile;
  end

endmodule

>>> hw/rtl/msoe_slot_counter.sv
// Object slot counter: assigns each request its table slot and marks requests
// that arrive once the table is full. Depends on msoe_pkg.
module msoe_slot_counter #(
  parameter int OBJ_SLOTS = msoe_pkg::OBJ_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic                        new_frame,
  output logic [msoe_pkg::SLOT_W-1:0] slot,
  output logic                        keep
);

  localparam int CNT_W = $clog2(OBJ_SLOTS + 1);

  logic [CNT_W-1:0] slot_count;
  logic [CNT_W-1:0] slot_count_next;
  logic [CNT_W-1:0] base;

  always_comb begin
    base = new_frame ? '0 : slot_count;
    keep = base < CNT_W'(OBJ_SLOTS);
    slot = msoe_pkg::SLOT_W'(base);
    slot_count_next = slot_count;
    if (take) begin
      slot_count_next = keep ? base + 1'b1 : base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
    end else begin
      slot_count <= slot_count_next;
    end
  end

  `include "metasprite_oam_expander_assert.svh"

  `MSOE_ASSERT(a_count_bound, slot_count <= CNT_W'(OBJ_SLOTS), "slot count past table size")
  `MSOE_ASSERT(a_frame_restart, take && new_frame |=> slot_count == CNT_W'(1), "frame start did not restart slots")
  `MSOE_ASSERT(a_count_step, take && !new_frame && keep |=> slot_count == $past(slot_count) + 1'b1, "slot count did not advance")
  `MSOE_ASSERT(a_full_hold, take && !keep |=> slot_count == $past(base), "full table changed the slot count")

endmodule

>>> hw/rtl/metasprite_oam_expander.sv
// Top level of the metasprite object attribute expander: input register,
// slot counter, entry logic and result register. Depends on msoe_pkg.
//
// Takes one metasprite part request per cycle while not stalled and returns its object
// attribute entry through two registers: the input register, where the slot is
// already assigned, and then the result register. The input register hands a kept
// entry to the result register whenever that register is empty or being read, so with
// m_axis_tready held high a request is accepted in every cycle. The input side stalls
// only while a kept entry sits in the input register behind a result that still waits
// for m_axis_tready. Once OBJ_SLOTS entries have been produced since the last request
// with new_frame set, further requests are accepted and dropped without a result.
module metasprite_oam_expander #(
  parameter int OBJ_SLOTS = msoe_pkg::OBJ_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // base_x, base_y, flip, tile_base, attr_zero, attr_one, attr_two,
  // part_dx, part_dy, tile_offset, pivot
  input  logic [msoe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // new_frame
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // slot_index, out_attr_zero, out_attr_one, out_attr_two, zero pad
  output logic [msoe_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic                        in_take;
  logic                        stage_valid;
  logic                        stage_keep;
  logic                        stage_adv;
  logic                        out_load;
  logic                        keep;
  logic [msoe_pkg::SLOT_W-1:0] slot;
  logic [msoe_pkg::SLOT_W-1:0] stage_slot;
  msoe_pkg::part_t             stage_part;
  msoe_pkg::entry_t            entry;
  msoe_pkg::entry_t            out_entry;

  assign out_load      = stage_valid && stage_keep && (!m_axis_tvalid || m_axis_tready);
  assign stage_adv     = !stage_valid || !stage_keep || !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = stage_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  msoe_slot_counter #(
    .OBJ_SLOTS(OBJ_SLOTS)
  ) u_slot_counter (
    .clk       (clk),
    .rst       (rst),
    .take      (in_take),
    .new_frame (s_axis_tuser),
    .slot      (slot),
    .keep      (keep)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_adv) begin
      stage_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_part <= msoe_pkg::part_t'(s_axis_tdata);
      stage_slot <= slot;
      stage_keep <= keep;
    end
  end

  msoe_part_calc u_part_calc (
    .part  (stage_part),
    .slot  (stage_slot),
    .entry (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_entry <= entry;
    end
  end

  assign m_axis_tdata = {1'b0, out_entry};

endmodule
